FILE: sv/ufrle_pkg.sv
// shared types and constants for the uart frame run-length encoder
// no dependencies; imported by ufrle_bound_table and uart_frame_run_length_encoder

package ufrle_pkg;

    localparam int BYTE_W    = 8;
    localparam int BAUD_W    = 21;
    localparam int BND_W     = 17;
    localparam int BND_COUNT = 11;
    localparam int DUR_W     = 15;
    localparam int POS_W     = 4;
    localparam int ACC_W     = 27;
    localparam int STEP_W    = 5;
    localparam int CNT_W     = 3;
    localparam int SYM_W     = 2 * DUR_W + 2;

    localparam logic [BAUD_W-1:0] BAUD_MIN      = 21'd110;
    localparam logic [BAUD_W-1:0] BAUD_FAST_MIN = 21'd4800;
    localparam logic [BAUD_W-1:0] BAUD_RESET    = 21'd115200;
    localparam logic [ACC_W-1:0]  RATE_FAST     = 27'd10000000;
    localparam logic [ACC_W-1:0]  RATE_SLOW     = 27'd1000000;

    localparam logic [STEP_W-1:0] DIV_STEP_LAST = STEP_W'(BND_W - 1);
    localparam logic [POS_W-1:0]  POS_LAST      = POS_W'(BND_COUNT - 1);
    localparam logic [CNT_W-1:0]  SYM_LAST      = 3'd6;

    typedef logic [BND_COUNT-1:0][BND_W-1:0] bnd_tbl_t;

    typedef enum logic [1:0] {
        BT_IDLE,
        BT_LOAD,
        BT_DIV
    } bt_state_t;

    typedef struct packed {
        logic [BND_COUNT-1:0][POS_W-1:0] nxt;
        logic [BND_COUNT-1:0]            lvl;
        logic [BND_COUNT-1:0][BND_W-1:0] dur;
    } run_t;

    typedef struct packed {
        logic             second_level;
        logic [DUR_W-1:0] second_duration;
        logic             first_level;
        logic [DUR_W-1:0] first_duration;
    } sym_t;

endpackage

FILE: sv/ufrle_bound_table.sv
// bit boundary table for the 8n1 frame, rebuilt on reset and on every baud write
// bit-serial restoring divider, one quotient bit per cycle in the divide state; uses ufrle_pkg

module ufrle_bound_table (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [ufrle_pkg::BAUD_W-1:0] cfg_wdata,
    output ufrle_pkg::bnd_tbl_t          bound_tbl,
    output logic                         busy
);
    import ufrle_pkg::*;

    bt_state_t          state_reg, state_next;
    logic [BAUD_W-1:0]  baud_reg, baud_next;
    logic [ACC_W-1:0]   acc_reg, acc_next;
    logic [BAUD_W-1:0]  rem_reg, rem_next;
    logic [BND_W-1:0]   lo_reg, lo_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [POS_W-1:0]   idx_reg, idx_next;
    bnd_tbl_t           tbl_reg;

    logic [BAUD_W-1:0]  baud_clamp;
    logic [ACC_W-1:0]   rate;
    logic [BAUD_W:0]    trial;
    logic               ge;
    logic               wr_en;

    assign baud_clamp = (cfg_wdata < BAUD_MIN) ? BAUD_MIN : cfg_wdata;
    assign rate       = (baud_reg >= BAUD_FAST_MIN) ? RATE_FAST : RATE_SLOW;
    assign trial      = {rem_reg, lo_reg[BND_W-1]};
    assign ge         = (trial >= {1'b0, baud_reg});

    always_comb begin
        state_next = state_reg;
        baud_next  = baud_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        step_next  = step_reg;
        idx_next   = idx_reg;
        wr_en      = 1'b0;
        unique case (state_reg)
            BT_IDLE: begin
            end
            BT_LOAD: begin
                rem_next   = BAUD_W'(acc_reg[ACC_W-1:BND_W]);
                lo_next    = acc_reg[BND_W-1:0];
                step_next  = '0;
                state_next = BT_DIV;
            end
            BT_DIV: begin
                rem_next  = ge ? BAUD_W'(trial - {1'b0, baud_reg}) : trial[BAUD_W-1:0];
                lo_next   = {lo_reg[BND_W-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == DIV_STEP_LAST) begin
                    wr_en    = 1'b1;
                    acc_next = acc_reg + rate;
                    if (idx_reg == POS_LAST) begin
                        state_next = BT_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = BT_LOAD;
                    end
                end
            end
            default: begin
                state_next = BT_IDLE;
            end
        endcase
        // a baud write restarts the whole table
        if (cfg_we) begin
            baud_next  = baud_clamp;
            acc_next   = ACC_W'(baud_clamp >> 1);
            idx_next   = '0;
            wr_en      = 1'b0;
            state_next = BT_LOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BT_LOAD;
            baud_reg  <= BAUD_RESET;
            acc_reg   <= ACC_W'(BAUD_RESET >> 1);
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            baud_reg  <= baud_next;
            acc_reg   <= acc_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        step_reg <= step_next;
        if (wr_en) begin
            tbl_reg[idx_reg] <= lo_next;
        end
    end

    assign bound_tbl = tbl_reg;
    assign busy      = (state_reg != BT_IDLE);

endmodule

FILE: sv/uart_frame_run_length_encoder.sv
// 8n1 frame to pulse symbol encoder: a taken byte is registered into the run register, its first
// symbol then into the output register; one symbol per cycle while the output is not stalled, and
// the next byte is taken in the cycle its predecessor's last symbol is formed; a byte has 1 to 7 symbols.
// after reset and after every baud write the boundary divider rebuilds all 11 entries
// with s_tready low. uses ufrle_pkg and ufrle_bound_table

module uart_frame_run_length_encoder #(
    parameter int DURATION_BITS = 15
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [ufrle_pkg::BAUD_W-1:0] cfg_wdata,   // baud_rate
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ufrle_pkg::BYTE_W-1:0] s_tdata,     // data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // first_duration, first_level, second_duration, second_level
    output logic [ufrle_pkg::SYM_W-1:0]  m_tdata,
    output logic                         m_tlast      // last_symbol
);
    import ufrle_pkg::*;

    localparam int HalfRaw = (1 << DURATION_BITS) - 1;
    localparam int HalfCapInt = (HalfRaw > 32767) ? 32767 : HalfRaw;
    localparam logic [BND_W-1:0] HALF_CAP = BND_W'(HalfCapInt);

    bnd_tbl_t          bound_tbl;
    logic              tbl_busy;

    logic              run_valid_reg, run_valid_next;
    run_t              run_reg, run_next, run_c;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [BND_W-1:0]  rem_reg, rem_next;
    logic              fresh_reg, fresh_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              m_valid_reg, m_valid_next;
    sym_t              m_data_reg, m_data_next;
    logic              m_last_reg, m_last_next;

    logic [BYTE_W+1:0] bits_c;
    logic [BND_COUNT-1:0] mask_c;

    logic              accept;
    logic              gen_fire;
    logic [BND_W-1:0]  d_cur, d_a, r_a, d_bin, d_b, r_b;
    logic              end_a, last_a, end_b, last_b;
    logic [POS_W-1:0]  k_b;
    sym_t              sym;
    logic              sym_done;

    ufrle_bound_table u_bound_table (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bound_tbl (bound_tbl),
        .busy      (tbl_busy)
    );

    // run boundaries of the incoming frame
    always_comb begin
        logic [POS_W-1:0] prv;
        bits_c    = {1'b1, s_tdata, 1'b0};
        mask_c    = '0;
        run_c     = '0;
        for (int k = 1; k < BND_COUNT - 1; k++) begin
            mask_c[k] = bits_c[k] ^ bits_c[k-1];
        end
        mask_c[BND_COUNT-1] = 1'b1;
        for (int k = 0; k < BND_COUNT - 1; k++) begin
            for (int j = BND_COUNT - 1; j > k; j--) begin
                if (mask_c[j]) begin
                    run_c.nxt[k] = POS_W'(j);
                end
            end
        end
        for (int k = 1; k < BND_COUNT; k++) begin
            prv = '0;
            for (int j = 1; j < k; j++) begin
                if (mask_c[j]) begin
                    prv = POS_W'(j);
                end
            end
            run_c.lvl[k] = bits_c[k-1];
            run_c.dur[k] = bound_tbl[k] - bound_tbl[prv];
        end
    end

    assign gen_fire = run_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !tbl_busy && (!run_valid_reg || (gen_fire && sym_done));
    assign accept   = s_tvalid && s_tready;

    // two halves per cycle while the output is not stalled, each capped, runs walked through the next-boundary list
    always_comb begin
        d_cur  = fresh_reg ? run_reg.dur[k_reg] : rem_reg;
        d_a    = (d_cur > HALF_CAP) ? HALF_CAP : d_cur;
        r_a    = d_cur - d_a;
        end_a  = (r_a == '0);
        last_a = end_a && (k_reg == POS_LAST);
        k_b    = end_a ? run_reg.nxt[k_reg] : k_reg;
        d_bin  = end_a ? run_reg.dur[k_b] : r_a;
        d_b    = (d_bin > HALF_CAP) ? HALF_CAP : d_bin;
        r_b    = d_bin - d_b;
        end_b  = (r_b == '0);
        last_b = end_b && (k_b == POS_LAST);
        sym.first_level = run_reg.lvl[k_reg];
        if (last_a) begin
            // odd half count: split the stop run's final piece
            sym.first_duration  = DUR_W'(d_a - (d_a >> 1));
            sym.second_duration = DUR_W'(d_a >> 1);
            sym.second_level    = 1'b1;
            sym_done            = 1'b1;
        end else begin
            sym.first_duration  = DUR_W'(d_a);
            sym.second_duration = DUR_W'(d_b);
            sym.second_level    = run_reg.lvl[k_b];
            sym_done            = last_b || (cnt_reg == SYM_LAST);
        end
    end

    always_comb begin
        run_valid_next = run_valid_reg;
        run_next       = run_reg;
        k_next         = k_reg;
        rem_next       = rem_reg;
        fresh_next     = fresh_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        m_last_next    = m_last_reg;
        if (gen_fire) begin
            k_next       = end_b ? run_reg.nxt[k_b] : k_b;
            rem_next     = r_b;
            fresh_next   = end_b;
            cnt_next     = cnt_reg + 1'b1;
            m_valid_next = 1'b1;
            m_data_next  = sym;
            m_last_next  = sym_done;
            if (sym_done) begin
                run_valid_next = 1'b0;
            end
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            run_valid_next = 1'b1;
            run_next       = run_c;
            k_next         = run_c.nxt[0];
            fresh_next     = 1'b1;
            cnt_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            run_valid_reg <= run_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_reg    <= run_next;
        k_reg      <= k_next;
        rem_reg    <= rem_next;
        fresh_reg  <= fresh_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // table rebuild after reset keeps the input closed
    a_reset_rebuild: assert property (@(posedge aclk) !aresetn |=> !s_tready)
        else $error("input open right after reset");

    a_first_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[DUR_W-1:0] != '0))
        else $error("symbol with empty first half");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        run_valid_reg |-> (k_reg <= POS_LAST))
        else $error("run position beyond frame end");

    a_symbol_count: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_fire && !sym_done |=> run_valid_reg && (cnt_reg != '0))
        else $error("frame dropped before its last symbol");

endmodule
